/* design/pts_pkg.sv */
// Shared types and codes for the priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

  // Event kinds.
  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_ACTIVATE  = 3'd1;
  localparam logic [2:0] KIND_TERMINATE = 3'd2;
  localparam logic [2:0] KIND_WAIT      = 3'd3;
  localparam logic [2:0] KIND_SET_PRIO  = 3'd4;
  localparam logic [2:0] KIND_START     = 3'd5;

  // Result status codes.
  localparam logic [2:0] STAT_OK            = 3'd0;
  localparam logic [2:0] STAT_NOT_INACTIVE  = 3'd1;
  localparam logic [2:0] STAT_ALREADY_INACT = 3'd2;
  localparam logic [2:0] STAT_NOT_RUNNING   = 3'd3;
  localparam logic [2:0] STAT_NOT_STARTED   = 3'd4;

  // Slot states.
  localparam logic [1:0] SLOT_INACTIVE = 2'd0;
  localparam logic [1:0] SLOT_READY    = 2'd1;
  localparam logic [1:0] SLOT_RUNNING  = 2'd2;
  localparam logic [1:0] SLOT_BLOCKED  = 2'd3;

  // Lowest urgency, also the reset priority.
  localparam logic [7:0] PRIO_LOWEST = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic tick;
    logic scan;
    logic demote;
    logic commit;
  } pts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_tick;
    logic go_sched;
    logic last;
  } pts_stat_t;

endpackage
`default_nettype wire

/* design/pts_ctrl.sv */
// Controller state machine that sequences one scheduler event.
`timescale 1ns / 1ps
`default_nettype none
module pts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t      cmd,
  output logic                   busy,
  output logic                   done
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_TICK   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DEMOTE = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_EXEC;
      S_EXEC: begin
        priority if (stat.go_tick) state_next = S_TICK;
        else if (stat.go_sched)    state_next = S_SCAN;
        else                       state_next = S_DONE;
      end
      S_TICK:   if (stat.last) state_next = S_SCAN;
      S_SCAN:   if (stat.last) state_next = S_DEMOTE;
      S_DEMOTE: state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command decode.
  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.exec   = (state == S_EXEC);
    cmd.tick   = (state == S_TICK);
    cmd.scan   = (state == S_SCAN);
    cmd.demote = (state == S_DEMOTE);
    cmd.commit = (state == S_COMMIT);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

/* design/pts_datapath.sv */
// Slot tables, current task registers and scan logic of the scheduler.
`timescale 1ns / 1ps
`default_nettype none
module pts_datapath #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pts_pkg::pts_cmd_t  cmd,
  input  wire logic [2:0]         kind,
  input  wire logic [3:0]         task_req,
  input  wire logic [31:0]        delay_ticks,
  input  wire logic [7:0]         new_priority,
  output pts_pkg::pts_stat_t      stat,
  output logic [2:0]              status,
  output logic [3:0]              running_task,
  output logic                    running_valid,
  output logic                    switch_request
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Slot tables.
  logic [7:0]  slot_priority     [MAX_TASKS];
  logic [1:0]  slot_state        [MAX_TASKS];
  logic [31:0] slot_delay        [MAX_TASKS];
  logic        slot_time_blocked [MAX_TASKS];

  // Latched event.
  logic [2:0]  ev_kind;
  logic [3:0]  ev_req;
  logic [31:0] ev_delay;
  logic [7:0]  ev_prio;

  // Scheduler state and scan registers.
  logic          os_running;
  logic [SW-1:0] current_slot;
  logic          current_valid;
  logic [SW-1:0] idx;
  logic [SW-1:0] cnt;
  logic [8:0]    best;
  logic [SW-1:0] best_slot;
  logic          found;
  logic [2:0]    status_r;
  logic          switch_r;

  // Combinational helpers.
  logic          req_ok;
  logic [SW-1:0] req_slot;
  logic [SW-1:0] addr;
  logic [1:0]    rd_state;
  logic [7:0]    rd_prio;
  logic [31:0]   rd_delay;
  logic          rd_tb;
  logic          eligible;
  logic [31:0]   dec_delay;
  logic [SW-1:0] cur_next;
  logic [SW-1:0] idx_next;

  // Write controls for the slot tables.
  logic          we_state;
  logic [1:0]    wd_state;
  logic          we_prio;
  logic          we_delay;
  logic [31:0]   wd_delay;
  logic          we_tb;
  logic          wd_tb;
  logic          go_tick;
  logic          go_sched;
  logic          set_status;
  logic [2:0]    status_next;

  assign req_ok   = (32'(ev_req) < MAX_TASKS);
  assign req_slot = SW'(ev_req);
  assign cur_next = (32'(current_slot) == MAX_TASKS - 1) ? '0 : current_slot + SW'(1);
  assign idx_next = (32'(idx) == MAX_TASKS - 1) ? '0 : idx + SW'(1);

  // One table address per cycle, chosen by the active command.
  always_comb begin
    priority if (cmd.tick || cmd.scan) addr = idx;
    else if (cmd.demote)               addr = current_slot;
    else if (cmd.commit)               addr = best_slot;
    else                               addr = req_slot;
  end

  assign rd_state  = slot_state[addr];
  assign rd_prio   = slot_priority[addr];
  assign rd_delay  = slot_delay[addr];
  assign rd_tb     = slot_time_blocked[addr];
  assign eligible  = (rd_state == pts_pkg::SLOT_READY) || (rd_state == pts_pkg::SLOT_RUNNING);
  assign dec_delay = rd_delay - 32'd1;

  // Event decode and table write controls.
  always_comb begin
    we_state    = 1'b0;
    wd_state    = rd_state;
    we_prio     = 1'b0;
    we_delay    = 1'b0;
    wd_delay    = dec_delay;
    we_tb       = 1'b0;
    wd_tb       = 1'b0;
    go_tick     = 1'b0;
    go_sched    = 1'b0;
    set_status  = 1'b0;
    status_next = pts_pkg::STAT_OK;
    if (cmd.exec) begin
      set_status = 1'b1;
      unique case (ev_kind)
        pts_pkg::KIND_TICK: begin
          if (!os_running) status_next = pts_pkg::STAT_NOT_STARTED;
          else go_tick = 1'b1;
        end
        pts_pkg::KIND_ACTIVATE: begin
          if (req_ok) begin
            if (rd_state != pts_pkg::SLOT_INACTIVE) begin
              status_next = pts_pkg::STAT_NOT_INACTIVE;
            end else begin
              we_state = 1'b1;
              wd_state = pts_pkg::SLOT_READY;
              go_sched = os_running;
            end
          end
        end
        pts_pkg::KIND_TERMINATE: begin
          if (req_ok) begin
            if (rd_state == pts_pkg::SLOT_INACTIVE) begin
              status_next = pts_pkg::STAT_ALREADY_INACT;
            end else begin
              we_state = 1'b1;
              wd_state = pts_pkg::SLOT_INACTIVE;
              we_tb    = 1'b1;
              wd_tb    = 1'b0;
              go_sched = os_running;
            end
          end
        end
        pts_pkg::KIND_WAIT: begin
          if (req_ok) begin
            priority if (!os_running) begin
              status_next = pts_pkg::STAT_NOT_STARTED;
            end else if (rd_state != pts_pkg::SLOT_RUNNING) begin
              status_next = pts_pkg::STAT_NOT_RUNNING;
            end else begin
              we_state = 1'b1;
              wd_state = pts_pkg::SLOT_BLOCKED;
              we_tb    = 1'b1;
              wd_tb    = 1'b1;
              we_delay = 1'b1;
              wd_delay = ev_delay;
              go_sched = 1'b1;
            end
          end
        end
        pts_pkg::KIND_SET_PRIO: begin
          if (req_ok) begin
            we_prio  = 1'b1;
            go_sched = os_running;
          end
        end
        pts_pkg::KIND_START: go_sched = 1'b1;
        default: ;
      endcase
    end else if (cmd.tick) begin
      // Count down time-blocked slots and release those that expire.
      if (rd_state == pts_pkg::SLOT_BLOCKED && rd_tb) begin
        we_delay = 1'b1;
        if (dec_delay == 32'd0) begin
          we_tb    = 1'b1;
          wd_tb    = 1'b0;
          we_state = 1'b1;
          wd_state = pts_pkg::SLOT_READY;
        end
      end
    end else if (cmd.demote) begin
      if (rd_state == pts_pkg::SLOT_RUNNING) begin
        we_state = 1'b1;
        wd_state = pts_pkg::SLOT_READY;
      end
    end else if (cmd.commit) begin
      if (found) begin
        we_state = 1'b1;
        wd_state = pts_pkg::SLOT_RUNNING;
      end
    end
  end

  // Slot tables with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_priority[i]     <= pts_pkg::PRIO_LOWEST;
        slot_state[i]        <= pts_pkg::SLOT_INACTIVE;
        slot_time_blocked[i] <= 1'b0;
      end
    end else begin
      if (we_state) slot_state[addr] <= wd_state;
      if (we_prio)  slot_priority[addr] <= ev_prio;
      if (we_tb)    slot_time_blocked[addr] <= wd_tb;
    end
  end

  // Delay counters are only read while their time-blocked flag is set.
  always_ff @(posedge clk) begin
    if (we_delay) slot_delay[addr] <= wd_delay;
  end

  // Latch the event on its transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_kind  <= kind;
      ev_req   <= task_req;
      ev_delay <= delay_ticks;
      ev_prio  <= new_priority;
    end
  end

  // Scan counter and running best candidate.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cnt   <= '0;
      idx   <= go_tick ? '0 : cur_next;
      best  <= 9'd256;
      found <= 1'b0;
    end else if (cmd.tick) begin
      cnt <= stat.last ? '0 : cnt + SW'(1);
      idx <= stat.last ? cur_next : idx_next;
    end else if (cmd.scan) begin
      cnt <= cnt + SW'(1);
      idx <= idx_next;
      // Strict compare keeps the first slot in cyclic order among equals.
      if (eligible && {1'b0, rd_prio} < best) begin
        best      <= {1'b0, rd_prio};
        best_slot <= idx;
        found     <= 1'b1;
      end
    end
  end

  // Mode, current task and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      os_running    <= 1'b0;
      current_slot  <= '0;
      current_valid <= 1'b0;
      status_r      <= pts_pkg::STAT_OK;
      switch_r      <= 1'b0;
    end else begin
      if (cmd.exec && ev_kind == pts_pkg::KIND_START) os_running <= 1'b1;
      if (set_status) begin
        status_r <= status_next;
        switch_r <= 1'b0;
      end
      if (cmd.commit) begin
        switch_r      <= (current_valid != found) || (found && current_slot != best_slot);
        current_slot  <= found ? best_slot : '0;
        current_valid <= found;
      end
    end
  end

  assign stat.go_tick  = go_tick;
  assign stat.go_sched = go_sched;
  assign stat.last     = (32'(cnt) == MAX_TASKS - 1);

  assign status         = status_r;
  assign running_task   = current_valid ? 4'(current_slot) : 4'd0;
  assign running_valid  = current_valid;
  assign switch_request = switch_r;

endmodule
`default_nettype wire

/* design/priority_task_scheduler.sv */
// Top level of the priority task scheduler: controller, datapath and checks.
//
//  Channel   Handshake        Payload
//  event     start / busy     kind, task_req, delay_ticks, new_priority
//  result    done (strobe)    status, running_task, running_valid, switch_request
//
// A rescheduling event scans all slots, then demotes and commits; a tick
// first counts down time-blocked slots. A slot table pass visits one slot a
// cycle through the single table address. Reset is synchronous and clears
// all slots to inactive at priority 255. The result is shown for one cycle
// on done and cannot be stalled; busy stays high until that cycle ends.
`timescale 1ns / 1ps
`default_nettype none
module priority_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind,
  input  wire logic [3:0]  task_req,
  input  wire logic [31:0] delay_ticks,
  input  wire logic [7:0]  new_priority,
  output logic             done,
  output logic [2:0]       status,
  output logic [3:0]       running_task,
  output logic             running_valid,
  output logic             switch_request
);

  pts_pkg::pts_cmd_t  cmd;
  pts_pkg::pts_stat_t stat;

  // Sequencer.
  pts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Slot tables and scan.
  pts_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .kind           (kind),
    .task_req       (task_req),
    .delay_ticks    (delay_ticks),
    .new_priority   (new_priority),
    .stat           (stat),
    .status         (status),
    .running_task   (running_task),
    .running_valid  (running_valid),
    .switch_request (switch_request)
  );

`ifndef NO_ASSERTIONS
  // A transfer in always starts a busy period.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted event did not raise busy");

  // The result strobe lasts one cycle and ends the busy period.
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

  // No task shown when none is running.
  a_idle_task: assert property (@(posedge clk) disable iff (rst)
    !running_valid |-> (running_task == 4'd0))
    else $error("running_task nonzero without a running task");

  // A switch is only requested on a rescheduling event's result.
  a_switch_done: assert property (@(posedge clk) disable iff (rst)
    (done && switch_request) |-> $past(cmd.commit, 1))
    else $error("switch request without a commit");
`endif

endmodule
`default_nettype wire
